FILE: sv/closest_point_on_triangle_defines.svh
// Assertion macros for the closest point on triangle block.
// Depends on nothing; taken in by the top level.
`ifndef CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH

// same-cycle implication
`define CPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closest point check failed");

// next-cycle implication
`define CPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closest point check failed");

`endif

FILE: sv/cpt_pkg.sv
// Types, widths and helpers shared by the closest point on triangle pipeline.
// Depends on nothing.
package cpt_pkg;

    localparam int CB  = 16;
    localparam int WFB = 16;
    localparam int DFW = CB + 1;
    localparam int DW  = 2 * DFW + 2;
    localparam int LB  = DW / 2;
    localparam int HB  = DW - LB;
    localparam int PW  = 2 * DW;
    localparam int VW  = PW + 2;
    localparam int RW  = VW + 1;
    localparam int QW  = WFB + 1;
    localparam int DSW = 2 * CB + 2;

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_C    = 3'd2,
        REG_AB   = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } t_region;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [DFW-1:0] x;
        logic signed [DFW-1:0] y;
        logic signed [DFW-1:0] z;
    } t_dvec;

    typedef struct packed {
        t_vec  p;
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec cb;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic signed [DW-1:0] d3;
        logic signed [DW-1:0] d4;
        logic signed [DW-1:0] d5;
        logic signed [DW-1:0] d6;
    } t_geo;

    typedef struct packed {
        t_vec    p;
        t_vec    base;
        t_dvec   e1;
        t_dvec   e2;
        t_region region;
        logic [RW-1:0]  den;
        logic [RW-1:0]  rem1;
        logic [RW-1:0]  rem2;
        logic [WFB-1:0] q1;
        logic [WFB-1:0] q2;
        logic z1;
        logic o1;
        logic z2;
        logic o2;
    } t_job;

    function automatic t_dvec dsub(t_vec u, t_vec v);
        t_dvec r;
        r.x = DFW'(u.x) - DFW'(v.x);
        r.y = DFW'(u.y) - DFW'(v.y);
        r.z = DFW'(u.z) - DFW'(v.z);
        return r;
    endfunction

endpackage

FILE: sv/cpt_dots.sv
// Edge vectors and the six dot products, three register stages.
// Depends on cpt_pkg.
module cpt_dots (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cpt_pkg::t_vec i_p,
    input  cpt_pkg::t_vec i_a,
    input  cpt_pkg::t_vec i_b,
    input  cpt_pkg::t_vec i_c,
    output logic          o_valid,
    input  logic          i_ready,
    output cpt_pkg::t_geo o_geo
);
    import cpt_pkg::*;

    localparam int NS = 3;

    typedef struct packed {
        t_vec  p;
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec ap;
        t_dvec bp;
        t_dvec cp;
        t_dvec cb;
    } t_ds0;

    typedef struct packed {
        t_vec  p;
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec cb;
        logic [5:0][2:0][2*DFW-1:0] m;
    } t_ds1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   en;
    t_ds0 r_s0, n_s0;
    t_ds1 r_s1, n_s1;
    t_geo r_s2, n_s2;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v = {r_v[NS-2:0], i_valid};
    end

    always_comb begin
        n_s0.p  = i_p;
        n_s0.a  = i_a;
        n_s0.b  = i_b;
        n_s0.c  = i_c;
        n_s0.ab = dsub(i_b, i_a);
        n_s0.ac = dsub(i_c, i_a);
        n_s0.ap = dsub(i_p, i_a);
        n_s0.bp = dsub(i_p, i_b);
        n_s0.cp = dsub(i_p, i_c);
        n_s0.cb = dsub(i_c, i_b);
    end

    always_comb begin
        t_dvec uu [6];
        t_dvec vv [6];
        logic signed [2*DFW-1:0] t0, t1, t2;
        uu[0] = r_s0.ab; vv[0] = r_s0.ap;
        uu[1] = r_s0.ac; vv[1] = r_s0.ap;
        uu[2] = r_s0.ab; vv[2] = r_s0.bp;
        uu[3] = r_s0.ac; vv[3] = r_s0.bp;
        uu[4] = r_s0.ab; vv[4] = r_s0.cp;
        uu[5] = r_s0.ac; vv[5] = r_s0.cp;
        n_s1.p  = r_s0.p;
        n_s1.a  = r_s0.a;
        n_s1.b  = r_s0.b;
        n_s1.c  = r_s0.c;
        n_s1.ab = r_s0.ab;
        n_s1.ac = r_s0.ac;
        n_s1.cb = r_s0.cb;
        for (int k = 0; k < 6; k++) begin
            t0 = uu[k].x * vv[k].x;
            t1 = uu[k].y * vv[k].y;
            t2 = uu[k].z * vv[k].z;
            n_s1.m[k][0] = t0;
            n_s1.m[k][1] = t1;
            n_s1.m[k][2] = t2;
        end
    end

    always_comb begin
        logic signed [DW-1:0] s [6];
        for (int k = 0; k < 6; k++) begin
            s[k] = DW'($signed(r_s1.m[k][0])) + DW'($signed(r_s1.m[k][1]))
                 + DW'($signed(r_s1.m[k][2]));
        end
        n_s2.p  = r_s1.p;
        n_s2.a  = r_s1.a;
        n_s2.b  = r_s1.b;
        n_s2.c  = r_s1.c;
        n_s2.ab = r_s1.ab;
        n_s2.ac = r_s1.ac;
        n_s2.cb = r_s1.cb;
        n_s2.d1 = s[0];
        n_s2.d2 = s[1];
        n_s2.d3 = s[2];
        n_s2.d4 = s[3];
        n_s2.d5 = s[4];
        n_s2.d6 = s[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
        if (en[1]) begin
            r_s1 <= n_s1;
        end
        if (en[2]) begin
            r_s2 <= n_s2;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_geo   = r_s2;

endmodule

FILE: sv/cpt_cross.sv
// Cross terms from split products, region classification and divider set-up.
// Depends on cpt_pkg.
module cpt_cross (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cpt_pkg::t_geo i_geo,
    output logic          o_valid,
    input  logic          i_ready,
    output cpt_pkg::t_job o_job
);
    import cpt_pkg::*;

    localparam int NS  = 5;
    localparam int DW1 = DW + 1;

    typedef struct packed {
        t_geo g;
        logic [5:0][3:0][PW-1:0] pp;
    } t_cs0;

    typedef struct packed {
        t_geo g;
        logic [5:0][PW-1:0] pr;
    } t_cs1;

    typedef struct packed {
        t_geo g;
        logic signed [VW-1:0] va;
        logic signed [VW-1:0] vb;
        logic signed [VW-1:0] vc;
    } t_cs2;

    typedef struct packed {
        t_vec    p;
        t_vec    base;
        t_dvec   e1;
        t_dvec   e2;
        t_region region;
        logic signed [VW-1:0] n1;
        logic signed [VW-1:0] n2;
        logic signed [VW-1:0] den;
    } t_cs3;

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   en;
    t_cs0 r_s0, n_s0;
    t_cs1 r_s1, n_s1;
    t_cs2 r_s2, n_s2;
    t_cs3 r_s3, n_s3;
    t_job r_s4, n_s4;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v = {r_v[NS-2:0], i_valid};
    end

    always_comb begin
        logic signed [DW-1:0] ox [6];
        logic signed [DW-1:0] oy [6];
        logic signed [HB-1:0] xh, yh;
        logic signed [LB:0]   xl, yl;
        logic signed [2*HB-1:0]  hh;
        logic signed [HB+LB:0]   hl, lh;
        logic signed [2*LB+1:0]  ll;
        ox[0] = i_geo.d1; oy[0] = i_geo.d4;
        ox[1] = i_geo.d3; oy[1] = i_geo.d2;
        ox[2] = i_geo.d5; oy[2] = i_geo.d2;
        ox[3] = i_geo.d1; oy[3] = i_geo.d6;
        ox[4] = i_geo.d3; oy[4] = i_geo.d6;
        ox[5] = i_geo.d5; oy[5] = i_geo.d4;
        n_s0.g = i_geo;
        for (int k = 0; k < 6; k++) begin
            xh = $signed(ox[k][DW-1:LB]);
            yh = $signed(oy[k][DW-1:LB]);
            xl = $signed({1'b0, ox[k][LB-1:0]});
            yl = $signed({1'b0, oy[k][LB-1:0]});
            hh = xh * yh;
            hl = xh * yl;
            lh = xl * yh;
            ll = xl * yl;
            n_s0.pp[k][0] = PW'(hh);
            n_s0.pp[k][1] = PW'(hl);
            n_s0.pp[k][2] = PW'(lh);
            n_s0.pp[k][3] = PW'(ll);
        end
    end

    always_comb begin
        n_s1.g = r_s0.g;
        for (int k = 0; k < 6; k++) begin
            n_s1.pr[k] = (r_s0.pp[k][0] << (2 * LB))
                       + ((r_s0.pp[k][1] + r_s0.pp[k][2]) << LB)
                       + r_s0.pp[k][3];
        end
    end

    always_comb begin
        n_s2.g  = r_s1.g;
        n_s2.vc = VW'($signed(r_s1.pr[0])) - VW'($signed(r_s1.pr[1]));
        n_s2.vb = VW'($signed(r_s1.pr[2])) - VW'($signed(r_s1.pr[3]));
        n_s2.va = VW'($signed(r_s1.pr[4])) - VW'($signed(r_s1.pr[5]));
    end

    always_comb begin
        logic signed [DW:0]   d43, d56;
        logic signed [VW-1:0] dsum;
        t_geo g;
        g    = r_s2.g;
        d43  = DW1'(g.d4) - DW1'(g.d3);
        d56  = DW1'(g.d5) - DW1'(g.d6);
        dsum = r_s2.va + r_s2.vb + r_s2.vc;
        n_s3.p      = g.p;
        n_s3.base   = g.a;
        n_s3.e1     = g.ab;
        n_s3.e2     = g.ac;
        n_s3.region = REG_A;
        n_s3.n1     = '0;
        n_s3.n2     = '0;
        n_s3.den    = '0;
        if (g.d1 <= 0 && g.d2 <= 0) begin
            n_s3.region = REG_A;
        end else if (g.d3 >= 0 && g.d4 <= g.d3) begin
            n_s3.region = REG_B;
            n_s3.base   = g.b;
        end else if (g.d6 >= 0 && g.d5 <= g.d6) begin
            n_s3.region = REG_C;
            n_s3.base   = g.c;
        end else if (r_s2.vc <= 0 && g.d1 >= 0 && g.d3 <= 0) begin
            n_s3.region = REG_AB;
            n_s3.n1     = VW'(g.d1);
            n_s3.den    = VW'(g.d1) - VW'(g.d3);
        end else if (r_s2.vb <= 0 && g.d2 >= 0 && g.d6 <= 0) begin
            n_s3.region = REG_AC;
            n_s3.e1     = g.ac;
            n_s3.n1     = VW'(g.d2);
            n_s3.den    = VW'(g.d2) - VW'(g.d6);
        end else if (r_s2.va <= 0 && d43 >= 0 && d56 >= 0) begin
            n_s3.region = REG_BC;
            n_s3.base   = g.b;
            n_s3.e1     = g.cb;
            n_s3.n1     = VW'(d43);
            n_s3.den    = VW'(d43) + VW'(d56);
        end else if (dsum <= 0) begin
            n_s3.region = REG_A;
        end else begin
            n_s3.region = REG_FACE;
            n_s3.n1     = r_s2.vb;
            n_s3.n2     = r_s2.vc;
            n_s3.den    = dsum;
        end
    end

    always_comb begin
        n_s4.p      = r_s3.p;
        n_s4.base   = r_s3.base;
        n_s4.e1     = r_s3.e1;
        n_s4.e2     = r_s3.e2;
        n_s4.region = r_s3.region;
        n_s4.den    = RW'(r_s3.den);
        n_s4.rem1   = RW'(r_s3.n1);
        n_s4.rem2   = RW'(r_s3.n2);
        n_s4.q1     = '0;
        n_s4.q2     = '0;
        n_s4.z1     = (r_s3.den <= 0) || (r_s3.n1 <= 0);
        n_s4.z2     = (r_s3.den <= 0) || (r_s3.n2 <= 0);
        n_s4.o1     = r_s3.n1 >= r_s3.den;
        n_s4.o2     = r_s3.n2 >= r_s3.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
        if (en[1]) begin
            r_s1 <= n_s1;
        end
        if (en[2]) begin
            r_s2 <= n_s2;
        end
        if (en[3]) begin
            r_s3 <= n_s3;
        end
        if (en[4]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_job   = r_s4;

endmodule

FILE: sv/cpt_div.sv
// Restoring division for two weights, one quotient bit per register stage.
// Depends on cpt_pkg.
module cpt_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cpt_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output cpt_pkg::t_job o_job
);
    import cpt_pkg::*;

    localparam int NS = WFB;

    function automatic t_job div_step(t_job j);
        t_job r;
        logic [RW-1:0] s1, s2;
        r  = j;
        s1 = {j.rem1[RW-2:0], 1'b0};
        s2 = {j.rem2[RW-2:0], 1'b0};
        if (s1 >= j.den) begin
            r.rem1 = s1 - j.den;
            r.q1   = {j.q1[WFB-2:0], 1'b1};
        end else begin
            r.rem1 = s1;
            r.q1   = {j.q1[WFB-2:0], 1'b0};
        end
        if (s2 >= j.den) begin
            r.rem2 = s2 - j.den;
            r.q2   = {j.q2[WFB-2:0], 1'b1};
        end else begin
            r.rem2 = s2;
            r.q2   = {j.q2[WFB-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   en;
    t_job r_j [NS];
    t_job n_j [NS];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v = {r_v[NS-2:0], i_valid};
        n_j[0] = div_step(i_job);
        for (int k = 1; k < NS; k++) begin
            n_j[k] = div_step(r_j[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_j[k] <= n_j[k];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_job   = r_j[NS-1];

endmodule

FILE: sv/cpt_blend.sv
// Weighted blend, rounding, saturation and squared distance; holds the output register.
// Depends on cpt_pkg.
module cpt_blend (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cpt_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output cpt_pkg::t_vec    o_cl,
    output logic [cpt_pkg::DSW-1:0] o_dsq,
    output cpt_pkg::t_region o_region
);
    import cpt_pkg::*;

    localparam int NS = 4;
    localparam int MW = DFW + QW + 1;
    localparam int MW1 = MW + 1;
    localparam int MW2 = MW + 2;
    localparam logic signed [MW:0]   HALF = MW1'(64'sd1 <<< (WFB - 1));
    localparam logic signed [MW+1:0] CMAX = MW2'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [MW+1:0] CMIN = -CMAX - MW2'(1);

    typedef struct packed {
        logic [2:0][CB-1:0] p;
        logic [2:0][CB-1:0] base;
        t_region            region;
        logic [2:0][MW-1:0] m1;
        logic [2:0][MW-1:0] m2;
    } t_bs0;

    typedef struct packed {
        logic [2:0][CB-1:0] p;
        logic [2:0][CB-1:0] cl;
        t_region            region;
    } t_bs1;

    typedef struct packed {
        logic [2:0][CB-1:0]    cl;
        logic [2:0][2*DFW-1:0] sq;
        t_region               region;
    } t_bs2;

    typedef struct packed {
        logic [2:0][CB-1:0] cl;
        logic [DSW-1:0]     dsq;
        t_region            region;
    } t_bs3;

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   en;
    t_bs0 r_s0, n_s0;
    t_bs1 r_s1, n_s1;
    t_bs2 r_s2, n_s2;
    t_bs3 r_s3, n_s3;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v = {r_v[NS-2:0], i_valid};
    end

    always_comb begin
        logic [QW-1:0] w1, w2;
        logic signed [QW:0] ws1, ws2;
        logic signed [DFW-1:0] ea [3];
        logic signed [DFW-1:0] eb [3];
        logic signed [MW-1:0] t1, t2;
        if (i_job.z1) begin
            w1 = '0;
        end else if (i_job.o1) begin
            w1 = QW'(1) << WFB;
        end else begin
            w1 = {1'b0, i_job.q1};
        end
        if (i_job.z2) begin
            w2 = '0;
        end else if (i_job.o2) begin
            w2 = QW'(1) << WFB;
        end else begin
            w2 = {1'b0, i_job.q2};
        end
        ws1 = $signed({1'b0, w1});
        ws2 = $signed({1'b0, w2});
        ea[0] = i_job.e1.x; ea[1] = i_job.e1.y; ea[2] = i_job.e1.z;
        eb[0] = i_job.e2.x; eb[1] = i_job.e2.y; eb[2] = i_job.e2.z;
        n_s0.p[0]    = i_job.p.x;
        n_s0.p[1]    = i_job.p.y;
        n_s0.p[2]    = i_job.p.z;
        n_s0.base[0] = i_job.base.x;
        n_s0.base[1] = i_job.base.y;
        n_s0.base[2] = i_job.base.z;
        n_s0.region  = i_job.region;
        for (int i = 0; i < 3; i++) begin
            t1 = ea[i] * ws1;
            t2 = eb[i] * ws2;
            n_s0.m1[i] = t1;
            n_s0.m2[i] = t2;
        end
    end

    always_comb begin
        logic signed [MW:0]   s, t;
        logic signed [MW+1:0] u;
        n_s1.p      = r_s0.p;
        n_s1.region = r_s0.region;
        for (int i = 0; i < 3; i++) begin
            s = MW1'($signed(r_s0.m1[i])) + MW1'($signed(r_s0.m2[i])) + HALF;
            t = s >>> WFB;
            u = MW2'(t) + MW2'($signed(r_s0.base[i]));
            if (u > CMAX) begin
                n_s1.cl[i] = CB'(CMAX);
            end else if (u < CMIN) begin
                n_s1.cl[i] = CB'(CMIN);
            end else begin
                n_s1.cl[i] = CB'(u);
            end
        end
    end

    always_comb begin
        logic signed [DFW-1:0]   dd;
        logic signed [2*DFW-1:0] sq;
        n_s2.cl     = r_s1.cl;
        n_s2.region = r_s1.region;
        for (int i = 0; i < 3; i++) begin
            dd = DFW'($signed(r_s1.p[i])) - DFW'($signed(r_s1.cl[i]));
            sq = dd * dd;
            n_s2.sq[i] = sq;
        end
    end

    always_comb begin
        n_s3.cl     = r_s2.cl;
        n_s3.region = r_s2.region;
        n_s3.dsq    = DSW'(r_s2.sq[0]) + DSW'(r_s2.sq[1]) + DSW'(r_s2.sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= n_s0;
        end
        if (en[1]) begin
            r_s1 <= n_s1;
        end
        if (en[2]) begin
            r_s2 <= n_s2;
        end
        if (en[3]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_ready  = en[0];
    assign o_valid  = r_v[NS-1];
    assign o_cl.x   = $signed(r_s3.cl[0]);
    assign o_cl.y   = $signed(r_s3.cl[1]);
    assign o_cl.z   = $signed(r_s3.cl[2]);
    assign o_dsq    = r_s3.dsq;
    assign o_region = r_s3.region;

endmodule

FILE: sv/closest_point_on_triangle.sv
// Top level of the closest point on triangle pipeline.
// Depends on cpt_pkg, cpt_dots, cpt_cross, cpt_div, cpt_blend and the defines header.
//
//   channel   handshake          payload
//   request   i_valid / o_stall  i_px .. i_cz, signed Q7.8
//   result    o_valid / i_stall  o_closest_x/y/z, o_dist_squared, o_region
//
// One request enters per cycle while o_stall is low. The pipeline holds the 16 quotient-bit
// stages of the weight divider plus 12 stages of products, classification and blend.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall on the result side fills empty stages first; o_stall rises only when all are full.
`include "closest_point_on_triangle_defines.svh"
module closest_point_on_triangle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic signed [15:0] i_pz,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_az,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    input  logic signed [15:0] i_bz,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_cy,
    input  logic signed [15:0] i_cz,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_closest_x,
    output logic signed [15:0] o_closest_y,
    output logic signed [15:0] o_closest_z,
    output logic [33:0]        o_dist_squared,
    output logic [2:0]         o_region
);
    import cpt_pkg::*;

    t_vec    p, a, b, c, cl;
    t_geo    geo;
    t_job    job_x, job_d;
    t_region region;
    logic    dots_rdy, dots_vld, cross_rdy, cross_vld, div_rdy, div_vld, blend_rdy;

    assign p = '{x: i_px, y: i_py, z: i_pz};
    assign a = '{x: i_ax, y: i_ay, z: i_az};
    assign b = '{x: i_bx, y: i_by, z: i_bz};
    assign c = '{x: i_cx, y: i_cy, z: i_cz};

    cpt_dots u_dots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (dots_rdy),
        .i_p     (p),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .o_valid (dots_vld),
        .i_ready (cross_rdy),
        .o_geo   (geo)
    );

    cpt_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dots_vld),
        .o_ready (cross_rdy),
        .i_geo   (geo),
        .o_valid (cross_vld),
        .i_ready (div_rdy),
        .o_job   (job_x)
    );

    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cross_vld),
        .o_ready (div_rdy),
        .i_job   (job_x),
        .o_valid (div_vld),
        .i_ready (blend_rdy),
        .o_job   (job_d)
    );

    cpt_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_vld),
        .o_ready  (blend_rdy),
        .i_job    (job_d),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_cl     (cl),
        .o_dsq    (o_dist_squared),
        .o_region (region)
    );

    assign o_stall     = !dots_rdy;
    assign o_closest_x = cl.x;
    assign o_closest_y = cl.y;
    assign o_closest_z = cl.z;
    assign o_region    = region;

    `CPT_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `CPT_ASSERT_IMP(a_free_flow, i_clk, i_rst_n, !i_stall, !o_stall)
    `CPT_ASSERT_NXT(a_full_keeps_result, i_clk, i_rst_n, o_stall, o_valid)

endmodule

FILE: tb/sv/tb.sv
// Testbench for closest_point_on_triangle: directed table, then random requests,
// checked field by field against a behavioural predictor. Depends on cpt_pkg and the RTL.
module tb;
    import cpt_pkg::*;

    typedef struct {
        logic signed [15:0] c[12];
    } t_req;

    typedef struct packed {
        logic signed [15:0] x, y, z;
        logic [33:0]        d;
        t_region            r;
    } t_res;

    typedef struct {
        t_req q;
        bit   known;
        t_res want;
    } t_row;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               i_stall = 0;
    logic signed [15:0] in_c[12];
    logic               o_stall, o_valid;
    logic signed [15:0] o_closest_x, o_closest_y, o_closest_z;
    logic [33:0]        o_dist_squared;
    logic [2:0]         o_region;

    t_res results_due[$];
    int   failures = 0;
    int   send_idle = 0, recv_idle = 0;

    always #1 i_clk = ~i_clk;

    closest_point_on_triangle i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_px(in_c[0]), .i_py(in_c[1]), .i_pz(in_c[2]),
        .i_ax(in_c[3]), .i_ay(in_c[4]), .i_az(in_c[5]),
        .i_bx(in_c[6]), .i_by(in_c[7]), .i_bz(in_c[8]),
        .i_cx(in_c[9]), .i_cy(in_c[10]), .i_cz(in_c[11]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_closest_x(o_closest_x), .o_closest_y(o_closest_y), .o_closest_z(o_closest_z),
        .o_dist_squared(o_dist_squared), .o_region(o_region)
    );

    function automatic longint wt(logic signed [127:0] num, logic signed [127:0] den);
        logic signed [127:0] n;
        longint q;
        q = 0;
        n = num;
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return 64'sd65536;
        for (int i = 0; i < 16; i++) begin
            n = n <<< 1;
            q = q << 1;
            if (n >= den) begin
                n = n - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic t_res nearest_point(t_req q);
        longint p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], cl[3];
        longint d1, d2, d3, d4, d5, d6, v, w, sqd;
        logic signed [127:0] va, vb, vc, den;
        t_res r;
        for (int i = 0; i < 3; i++) begin
            p[i] = q.c[i]; a[i] = q.c[3+i]; b[i] = q.c[6+i]; c[i] = q.c[9+i];
            ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i];
            ap[i] = p[i] - a[i]; bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i];
        end
        d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
        d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
        d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
        d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
        d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
        d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
        vc = 128'(d1) * 128'(d4) - 128'(d3) * 128'(d2);
        vb = 128'(d5) * 128'(d2) - 128'(d1) * 128'(d6);
        va = 128'(d3) * 128'(d6) - 128'(d5) * 128'(d4);
        if (d1 <= 0 && d2 <= 0) begin
            r.r = REG_A; cl = a;
        end else if (d3 >= 0 && d4 <= d3) begin
            r.r = REG_B; cl = b;
        end else if (d6 >= 0 && d5 <= d6) begin
            r.r = REG_C; cl = c;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            r.r = REG_AB;
            v = wt(128'(d1), 128'(d1 - d3));
            for (int i = 0; i < 3; i++) cl[i] = clip(a[i] + rnd16(ab[i] * v));
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            r.r = REG_AC;
            w = wt(128'(d2), 128'(d2 - d6));
            for (int i = 0; i < 3; i++) cl[i] = clip(a[i] + rnd16(ac[i] * w));
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            r.r = REG_BC;
            w = wt(128'(d4 - d3), 128'((d4 - d3) + (d5 - d6)));
            for (int i = 0; i < 3; i++) cl[i] = clip(b[i] + rnd16((c[i] - b[i]) * w));
        end else begin
            den = va + vb + vc;
            if (den <= 0) begin
                r.r = REG_A; cl = a;
            end else begin
                r.r = REG_FACE;
                v = wt(vb, den);
                w = wt(vc, den);
                for (int i = 0; i < 3; i++)
                    cl[i] = clip(a[i] + rnd16(ab[i] * v + ac[i] * w));
            end
        end
        sqd = 0;
        for (int i = 0; i < 3; i++) sqd += (p[i] - cl[i]) * (p[i] - cl[i]);
        r.x = 16'(cl[0]); r.y = 16'(cl[1]); r.z = 16'(cl[2]);
        r.d = sqd[33:0];
        return r;
    endfunction

    function automatic t_req pack(longint v[12]);
        t_req q;
        foreach (v[i]) q.c[i] = 16'(v[i]);
        return q;
    endfunction

    function automatic t_req rand_req(int shape);
        t_req q;
        int span;
        span = (shape == 0) ? 32767 : ((shape == 1) ? 2000 : 200);
        foreach (q.c[i]) begin
            if (shape == 0) q.c[i] = 16'($urandom);
            else q.c[i] = 16'(int'($urandom_range(2 * span)) - span);
        end
        if (shape == 3) for (int i = 0; i < 3; i++) q.c[9+i] = q.c[6+i];
        return q;
    endfunction

    task automatic send(t_req q, bit known, t_res want);
        t_res got;
        got = nearest_point(q);
        if (known && got != want) begin
            $error("table row disagrees with predictor");
            failures++;
        end
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        in_c <= q.c;
        results_due.insert(results_due.size(), known ? want : got);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $error("result with none expected");
                    failures++;
                end else begin
                    t_res e;
                    e = results_due.pop_front();
                    if (o_closest_x !== e.x) begin
                        $error("closest_x expected %0d got %0d", e.x, o_closest_x);
                        failures++;
                    end
                    if (o_closest_y !== e.y) begin
                        $error("closest_y expected %0d got %0d", e.y, o_closest_y);
                        failures++;
                    end
                    if (o_closest_z !== e.z) begin
                        $error("closest_z expected %0d got %0d", e.z, o_closest_z);
                        failures++;
                    end
                    if (o_dist_squared !== e.d) begin
                        $error("dist_squared expected %0d got %0d", e.d, o_dist_squared);
                        failures++;
                    end
                    if (o_region !== e.r) begin
                        $error("region expected %0d got %0d", e.r, o_region);
                        failures++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial begin
        t_row rows[$];
        t_res zero_res;
        foreach (in_c[i]) in_c[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        zero_res = '{0, 0, 0, 0, REG_A};
        rows.insert(rows.size(), '{pack('{0,0,0, 0,0,0, 0,0,0, 0,0,0}), 1, zero_res});
        rows.insert(rows.size(), '{pack('{-256,0,0, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{0, 0, 0, 34'd65536, REG_A}});
        rows.insert(rows.size(), '{pack('{512,0,0, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{256, 0, 0, 34'd65536, REG_B}});
        rows.insert(rows.size(), '{pack('{0,512,0, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{0, 256, 0, 34'd65536, REG_C}});
        rows.insert(rows.size(), '{pack('{128,-256,0, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{128, 0, 0, 34'd65536, REG_AB}});
        rows.insert(rows.size(), '{pack('{-256,128,0, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{0, 128, 0, 34'd65536, REG_AC}});
        rows.insert(rows.size(), '{pack('{64,64,256, 0,0,0, 256,0,0, 0,256,0}), 1,
                                   '{64, 64, 0, 34'd65536, REG_FACE}});
        rows.insert(rows.size(), '{pack('{256,256,0, 0,0,0, 256,0,0, 0,256,0}), 0,
                                   zero_res});
        rows.insert(rows.size(), '{pack('{32767,32767,32767, -32768,-32768,-32768,
                                   32767,-32768,-32768, -32768,32767,-32768}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{-32768,-32768,-32768, 32767,32767,32767,
                                   -32768,32767,32767, 32767,-32768,32767}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{100,50,7, 0,0,0, 0,0,0, 300,0,0}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{100,50,7, 0,0,0, 300,0,0, 0,0,0}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{100,50,7, 0,0,0, 100,0,0, 300,0,0}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{1,1,1, 0,0,0, 3,0,0, 0,3,0}), 0, zero_res});
        rows.insert(rows.size(), '{pack('{-1,-1,-1, 1,0,0, 0,1,0, 0,0,1}), 0, zero_res});
        foreach (rows[i]) send(rows[i].q, rows[i].known, rows[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 33 : ((ph == 1) ? 71 : 0);
            recv_idle = (ph == 0) ? 71 : ((ph == 1) ? 33 : 0);
            for (int n = 0; n < 630; n++) begin
                if (n == 300) begin
                    i_valid <= 0;
                    @(posedge i_clk);
                    while (results_due.size() != 0) @(posedge i_clk);
                end
                send(rand_req($urandom_range(3)), 0, zero_res);
            end
        end
        i_valid <= 0;
        recv_idle = 0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (failures == 0)
            $display("closest_point_on_triangle: match");
        else
            $display("closest_point_on_triangle: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("closest_point_on_triangle: mismatch");
        $finish;
    end
endmodule
